FILE: rtl/bau_pkg.sv
// ----------------------------------------------------------------------------
// BCD arithmetic unit package
// Operation codes, beat layouts and request/response types shared by the
// BCD arithmetic unit and its datapath.
// ----------------------------------------------------------------------------
package bau_pkg;

  // Operation selector carried on the slave-side tuser.
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_NEG    = 3'd2,
    OP_PACK   = 3'd3,
    OP_UNPACK = 3'd4
  } bau_op_t;

  // Widths of the stream ports.
  localparam int unsigned ReqDataW = 48;
  localparam int unsigned OpW      = 3;
  localparam int unsigned RspDataW = 24;

  // Decimal constants.
  localparam logic [9:0] BcdByteMax = 10'h099;
  localparam logic [9:0] HighAdj    = 10'h060;
  localparam logic [9:0] LowAdj     = 10'h006;
  localparam logic [4:0] DigitMax   = 5'd9;

  // One request as held in the input register.
  typedef struct packed {
    bau_op_t     req_type;
    logic [15:0] src_value;
    logic [7:0]  dst_value;
    logic [15:0] adjust;
    logic        x_in;
    logic        z_in;
  } bau_req_t;

  // One response as held in the result register.
  typedef struct packed {
    logic [15:0] result;
    logic        flags_valid;
    logic        carry_extend;
    logic        negative;
    logic        zero;
  } bau_rsp_t;

endpackage

FILE: rtl/bcd_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// BCD arithmetic unit
// Packed-BCD execution unit: decimal add, subtract, negate, pack and unpack.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the slave stream (s_*), one operation per beat, with
//   the operation code on s_tuser and the operands on s_tdata. Each request
//   yields exactly one response beat on the master stream (m_*), in order.
//   The request is captured in an input register, worked out by single-pass
//   combinational logic, and held in a result register. A response beat is
//   presented from the result register after its request has moved on from
//   the input register, and is handed over while m_tready is high.
//   Throughput is one beat per cycle: both registers advance together while
//   the receiver takes beats, and s_tready stays high whenever the input
//   register is empty or moving on.
//   When the receiver stalls, the result register holds its beat and the
//   input register fills; after that s_tready drops until m_tready returns.
//   Reset empties both registers; no beat is presented after reset until a
//   new request has been taken. The unit keeps no state between requests.
// ----------------------------------------------------------------------------
module bcd_arithmetic_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // src_value[15:0], dst_value[23:16], adjust[39:24], x_in[40], z_in[41], zero fill
  input  logic [bau_pkg::ReqDataW-1:0]   s_tdata,
  // req_type[2:0]
  input  logic [bau_pkg::OpW-1:0]        s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // result[15:0], carry_extend[16], negative[17], zero[18], zero fill
  output logic [bau_pkg::RspDataW-1:0]   m_tdata,
  // flags_valid[0]
  output logic                            m_tuser
);
  import bau_pkg::*;

  logic     in_valid;
  bau_req_t in_item;
  logic     out_valid;
  bau_rsp_t out_item;
  bau_rsp_t calc_rsp;
  logic     out_load;
  logic     in_load;

  // Stage advance: the result register takes a beat when empty or drained.
  assign out_load = !out_valid || m_tready;
  assign s_tready = !in_valid || out_load;
  assign in_load  = s_tvalid && s_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_item.req_type  <= bau_op_t'(s_tuser);
      in_item.src_value <= s_tdata[15:0];
      in_item.dst_value <= s_tdata[23:16];
      in_item.adjust    <= s_tdata[39:24];
      in_item.x_in      <= s_tdata[40];
      in_item.z_in      <= s_tdata[41];
    end
  end

  // Datapath.
  bau_calc u_calc (
    .req (in_item),
    .rsp (calc_rsp)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid) begin
      out_item <= calc_rsp;
    end
  end

  // Output beat packing.
  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_item.zero, out_item.negative, out_item.carry_extend,
                     out_item.result};
  assign m_tuser  = out_item.flags_valid;

  // A taken request always occupies the input register on the next cycle.
  a_in_capture: assert property (@(posedge clk) disable iff (rst)
    in_load |=> in_valid)
    else $error("accepted request not held in input register");

  // Pack, unpack and unused codes give no flags.
  a_no_flags: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[18:16] == 3'b000))
    else $error("flags set on a response without flags");

  // Flag-setting operations give a byte result whose bit 7 is the N flag.
  a_byte_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> ((m_tdata[15:8] == 8'h00) && (m_tdata[17] == m_tdata[7])))
    else $error("decimal result not a byte or N flag mismatch");

  // A nonzero decimal result always clears Z.
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser && (m_tdata[7:0] != 8'h00)) |-> !m_tdata[18])
    else $error("zero flag set on a nonzero result");

endmodule

FILE: rtl/bau_calc.sv
// ----------------------------------------------------------------------------
// BCD arithmetic unit datapath
// Single-pass combinational logic: decimal add, subtract and negate with
// condition flags, and the pack and unpack digit rearrangements.
// ----------------------------------------------------------------------------
module bau_calc (
  input  bau_pkg::bau_req_t req,
  output bau_pkg::bau_rsp_t rsp
);
  import bau_pkg::*;

  // Decimal byte add; returns {carry, byte}.
  function automatic logic [8:0] dec_add(input logic [7:0] s, input logic [7:0] d,
                                         input logic x);
    logic [4:0] lo;
    logic [9:0] sum;
    logic       cy;
    lo  = {1'b0, s[3:0]} + {1'b0, d[3:0]} + {4'b0, x};
    sum = {2'b0, s} + {2'b0, d} + {9'b0, x};
    if (lo > DigitMax) begin
      sum = sum + LowAdj;
    end
    cy = (sum > BcdByteMax);
    if (cy) begin
      sum = sum + HighAdj;
    end
    return {cy, sum[7:0]};
  endfunction

  // Decimal byte subtract d - s - x; returns {borrow, byte}.
  // The difference is kept in ten bits of two's complement, bit 9 the sign.
  function automatic logic [8:0] dec_sub(input logic [7:0] s, input logic [7:0] d,
                                         input logic x);
    logic       lo_bw;
    logic [9:0] diff;
    logic       bw;
    lo_bw = ({1'b0, d[3:0]} < ({1'b0, s[3:0]} + {4'b0, x}));
    diff  = {2'b0, d} - {2'b0, s} - {9'b0, x};
    if (lo_bw) begin
      diff = diff - LowAdj;
    end
    bw = diff[9];
    if (bw) begin
      diff = diff - HighAdj;
    end
    return {bw, diff[7:0]};
  endfunction

  logic [8:0]  add_out;
  logic [8:0]  sub_out;
  logic [8:0]  neg_out;
  logic [15:0] pack_sum;
  logic [15:0] unpk_sum;
  logic [7:0]  arith_byte;

  // All candidate results are formed in parallel.
  assign add_out  = dec_add(req.src_value[7:0], req.dst_value, req.x_in);
  assign sub_out  = dec_sub(req.src_value[7:0], req.dst_value, req.x_in);
  assign neg_out  = dec_sub(req.src_value[7:0], 8'h00, req.x_in);
  assign pack_sum = req.src_value + req.adjust;
  assign unpk_sum = {4'h0, req.src_value[7:4], 4'h0, req.src_value[3:0]} + req.adjust;

  // Select the result and flags by operation.
  always_comb begin
    rsp        = '0;
    arith_byte = '0;
    case (req.req_type)
      OP_ADD, OP_SUB, OP_NEG: begin
        if (req.req_type == OP_ADD) begin
          arith_byte       = add_out[7:0];
          rsp.carry_extend = add_out[8];
        end else if (req.req_type == OP_SUB) begin
          arith_byte       = sub_out[7:0];
          rsp.carry_extend = sub_out[8];
        end else begin
          arith_byte       = neg_out[7:0];
          rsp.carry_extend = neg_out[8];
        end
        rsp.result      = {8'h00, arith_byte};
        rsp.flags_valid = 1'b1;
        rsp.negative    = arith_byte[7];
        rsp.zero        = (arith_byte == 8'h00) ? req.z_in : 1'b0;
      end
      OP_PACK: begin
        rsp.result = {8'h00, pack_sum[11:8], pack_sum[3:0]};
      end
      OP_UNPACK: begin
        rsp.result = unpk_sum;
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

endmodule
